// ===== rtl/bdeq_pkg.sv =====
package bdeq_pkg;

    // default sizes
    localparam int DEF_NUM_BUTTONS = 8;
    localparam int DEF_QUEUE_DEPTH = 16;

    // field widths
    localparam int MODE_W   = 2;
    localparam int BIDX_W   = 3;
    localparam int TIME_W   = 32;
    localparam int LOCK_W   = 16;
    localparam int MASK_W   = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // register reset values
    localparam logic [LOCK_W-1:0] LOCKOUT_MS_RESET      = 16'd20;
    localparam logic              INVERT_LEVELS_RESET   = 1'b0;
    localparam logic [MASK_W-1:0] ENABLED_MASK_RESET    = 8'hFF;
    localparam logic [MASK_W-1:0] INITIAL_LEVELS_RESET  = 8'h00;

    // item modes
    localparam logic [MODE_W-1:0] MODE_PIN   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;
    localparam logic [MODE_W-1:0] MODE_START = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLED  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL  = 8'd3;

    typedef struct packed {
        logic [LOCK_W-1:0] lockout_ms;
        logic              invert_levels;
        logic [MASK_W-1:0] enabled_mask;
        logic [MASK_W-1:0] initial_levels;
    } t_cfg;

    typedef struct packed {
        logic event_valid;
        logic change_accepted;
        logic dropped;
    } t_flags;

endpackage

// ===== rtl/button_debounce_event_queue.sv =====
// a taken input word is held in the input register, its result then in the result register
// throughput: one word per cycle, input register and result register both advance
//   whenever the result register is empty or being taken
// reset: synchronous active low; state, pointers, valid flags and config registers return to defaults,
//   queue storage is not cleared, the fill count alone marks it empty
module button_debounce_event_queue #(
    parameter int NUM_BUTTONS = bdeq_pkg::DEF_NUM_BUTTONS,
    parameter int QUEUE_DEPTH = bdeq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bdeq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bdeq_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input words
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [bdeq_pkg::MODE_W-1:0]       i_mode,
    input  logic [bdeq_pkg::BIDX_W-1:0]       i_button_index,
    input  logic                              i_pin_level,
    input  logic [bdeq_pkg::TIME_W-1:0]       i_now_ms,
    // result words
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_event_valid,
    output logic [2*NUM_BUTTONS-1:0]          o_button_codes,
    output logic                              o_change_accepted,
    output logic                              o_dropped,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]  o_queue_count
);
    import bdeq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cfg                   cfg;
    logic                   advance;

    logic                   r_in_valid;
    logic [MODE_W-1:0]      r_mode;
    logic [BIDX_W-1:0]      r_button_index;
    logic                   r_pin_level;
    logic [TIME_W-1:0]      r_now_ms;

    t_flags                 res_flags;
    logic [2*NUM_BUTTONS-1:0] res_codes;
    logic [CNT_W-1:0]       res_count;

    logic                   r_out_valid;
    t_flags                 r_flags;
    logic [2*NUM_BUTTONS-1:0] r_codes;
    logic [CNT_W-1:0]       r_count;

    assign o_cfg_ready = 1'b1;

    bdeq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // handshake, the word in the input register moves on when the result slot frees
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_mode         <= i_mode;
            r_button_index <= i_button_index;
            r_pin_level    <= i_pin_level;
            r_now_ms       <= i_now_ms;
        end
    end

    bdeq_core #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (advance),
        .i_cfg          (cfg),
        .i_mode         (r_mode),
        .i_button_index (r_button_index),
        .i_pin_level    (r_pin_level),
        .i_now_ms       (r_now_ms),
        .o_flags        (res_flags),
        .o_button_codes (res_codes),
        .o_queue_count  (res_count)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_flags <= res_flags;
            r_codes <= res_codes;
            r_count <= res_count;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_event_valid     = r_flags.event_valid;
    assign o_button_codes    = r_codes;
    assign o_change_accepted = r_flags.change_accepted;
    assign o_dropped         = r_flags.dropped;
    assign o_queue_count     = r_count;

`ifndef SYNTHESIS
    // a lost word only happens with a full queue
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_dropped) |-> (o_queue_count == CNT_W'(QUEUE_DEPTH)))
        else $error("word dropped while queue not full");

    // a queued word leaves the queue non-empty
    a_accept_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_change_accepted) |-> (o_queue_count != '0))
        else $error("accepted word but queue empty");

    // codes are only reported with a dequeued event
    a_codes_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_event_valid) |-> (o_button_codes == '0))
        else $error("button codes without an event");

    // one result never both queues and dequeues
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_event_valid && (o_change_accepted || o_dropped)))
        else $error("conflicting result flags");
`endif

endmodule

// ===== rtl/bdeq_ram.sv =====
module bdeq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bdeq_cfg.sv =====
module bdeq_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [bdeq_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bdeq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output bdeq_pkg::t_cfg                 o_cfg
);
    import bdeq_pkg::*;

    t_cfg r_cfg, n_cfg;

    // register write decode, unknown indexes are ignored
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LOCKOUT: n_cfg.lockout_ms     = i_cfg_data[LOCK_W-1:0];
                CFG_INVERT:  n_cfg.invert_levels  = i_cfg_data[0];
                CFG_ENABLED: n_cfg.enabled_mask   = i_cfg_data[MASK_W-1:0];
                CFG_INITIAL: n_cfg.initial_levels = i_cfg_data[MASK_W-1:0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lockout_ms     <= LOCKOUT_MS_RESET;
            r_cfg.invert_levels  <= INVERT_LEVELS_RESET;
            r_cfg.enabled_mask   <= ENABLED_MASK_RESET;
            r_cfg.initial_levels <= INITIAL_LEVELS_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/bdeq_core.sv =====
module bdeq_core #(
    parameter int NUM_BUTTONS = bdeq_pkg::DEF_NUM_BUTTONS,
    parameter int QUEUE_DEPTH = bdeq_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  bdeq_pkg::t_cfg                    i_cfg,
    input  logic [bdeq_pkg::MODE_W-1:0]       i_mode,
    input  logic [bdeq_pkg::BIDX_W-1:0]       i_button_index,
    input  logic                              i_pin_level,
    input  logic [bdeq_pkg::TIME_W-1:0]       i_now_ms,
    output bdeq_pkg::t_flags                  o_flags,
    output logic [2*NUM_BUTTONS-1:0]          o_button_codes,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]  o_queue_count
);
    import bdeq_pkg::*;

    localparam int AW    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int BI_W  = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    logic [NUM_BUTTONS-1:0] r_levels, n_levels;
    logic [NUM_BUTTONS-1:0] r_last_deq, n_last_deq;
    logic [TIME_W-1:0]      r_stamp [NUM_BUTTONS];
    logic [AW-1:0]          r_head, n_head;
    logic [CNT_W-1:0]       r_fill, n_fill;
    logic                   r_byp_hit;
    logic [NUM_BUTTONS-1:0] r_byp_data;

    logic [BI_W-1:0]        bsel;
    logic                   level;
    logic                   idx_ok;
    logic                   late;
    logic [TIME_W-1:0]      elapsed;
    logic                   change;
    logic                   full;
    logic                   push;
    logic                   push_ok;
    logic                   pop;
    logic [NUM_BUTTONS-1:0] pin_word;
    logic [NUM_BUTTONS-1:0] push_word;
    logic [NUM_BUTTONS-1:0] ram_rdata;
    logic [NUM_BUTTONS-1:0] head_word;
    logic [2*NUM_BUTTONS-1:0] codes;
    logic [AW:0]            tail_sum;
    logic [AW-1:0]          tail;
    logic [AW-1:0]          head_inc;
    logic                   we;

    // pin change qualification
    assign bsel    = i_button_index[BI_W-1:0];
    assign level   = i_pin_level ^ i_cfg.invert_levels;
    assign idx_ok  = {1'b0, i_button_index} < (BIDX_W+1)'(NUM_BUTTONS);
    assign elapsed = i_now_ms - r_stamp[bsel];
    assign late    = elapsed >= TIME_W'(i_cfg.lockout_ms);
    assign change  = (i_mode == MODE_PIN) && idx_ok && i_cfg.enabled_mask[i_button_index]
                     && (r_levels[bsel] != level) && late;

    // new state word for a pin change
    always_comb begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            pin_word[i] = (BI_W'(i) == bsel) ? level : r_levels[i];
        end
    end

    // queue control
    assign full      = r_fill == CNT_W'(QUEUE_DEPTH);
    assign push      = change || (i_mode == MODE_START);
    assign push_word = (i_mode == MODE_START) ? i_cfg.initial_levels[NUM_BUTTONS-1:0]
                                              : pin_word;
    assign push_ok   = push && !full;
    assign pop       = (i_mode == MODE_POP) && (r_fill != '0);
    assign tail_sum  = (AW+1)'(r_head) + (AW+1)'(r_fill);
    assign tail      = (tail_sum >= (AW+1)'(QUEUE_DEPTH))
                       ? AW'(tail_sum - (AW+1)'(QUEUE_DEPTH)) : tail_sum[AW-1:0];
    assign head_inc  = (r_head == AW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign we        = i_en && push_ok;

    // head word, forwarded when it was written in the previous cycle
    assign head_word = r_byp_hit ? r_byp_data : ram_rdata;

    // per button event codes against the previously dequeued word
    always_comb begin
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            codes[2*i +: 2] = {head_word[i] == r_last_deq[i], head_word[i]};
        end
    end

    // next state
    always_comb begin
        n_levels   = r_levels;
        n_last_deq = r_last_deq;
        n_head     = r_head;
        n_fill     = r_fill;
        if (i_en) begin
            case (i_mode)
                MODE_PIN: begin
                    if (change) begin
                        n_levels = pin_word;
                    end
                end
                MODE_POP: begin
                    if (pop) begin
                        n_last_deq = head_word;
                        n_head     = head_inc;
                        n_fill     = r_fill - 1'b1;
                    end
                end
                MODE_CLEAR: begin
                    n_head = '0;
                    n_fill = '0;
                end
                MODE_START: begin
                    n_levels = i_cfg.initial_levels[NUM_BUTTONS-1:0];
                end
                default: begin
                    n_levels = r_levels;
                end
            endcase
            if (push_ok) begin
                n_fill = r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_levels   <= '0;
            r_last_deq <= '0;
            r_head     <= '0;
            r_fill     <= '0;
            r_byp_hit  <= 1'b0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_stamp[i] <= '0;
            end
        end else begin
            r_levels   <= n_levels;
            r_last_deq <= n_last_deq;
            r_head     <= n_head;
            r_fill     <= n_fill;
            r_byp_hit  <= we && (tail == n_head);
            if (i_en && change) begin
                r_stamp[bsel] <= i_now_ms;
            end
        end
    end

    // forwarded word needs no reset
    always_ff @(posedge i_clk) begin
        r_byp_data <= push_word;
    end

    // event storage, read ahead at the next head
    bdeq_ram #(
        .WIDTH (NUM_BUTTONS),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (tail),
        .i_wdata (push_word),
        .i_raddr (n_head),
        .o_rdata (ram_rdata)
    );

    // result of this word
    assign o_flags.event_valid     = pop;
    assign o_flags.change_accepted = push_ok;
    assign o_flags.dropped         = push && full;
    assign o_button_codes          = pop ? codes : '0;
    assign o_queue_count           = n_fill;

endmodule
